@@ rtl/core/plist_pkg.sv @@
package plist_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POSW         = 7;
    localparam int WORDW        = 32;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FIN
    } t_state;

    localparam logic signed [WORDW-1:0] ERR_DATA = -32'sd1;

    typedef struct packed {
        t_op                     op;
        logic [POSW-1:0]         position;
        logic signed [WORDW-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic signed [WORDW-1:0] data_out;
        logic [POSW-1:0]         found_at;
        logic [POSW-1:0]         count_after;
        logic                    is_empty;
    } t_rsp;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                    locate;
        logic                    ins;
        logic                    del;
        logic [POSW-1:0]         pos;
        logic signed [WORDW-1:0] value;
    } t_cell_ctl;

    // result bus handed from cell to cell toward the head of the list
    typedef struct packed {
        logic                    hit;
        logic signed [WORDW-1:0] word;
        logic [POSW-1:0]         place;
    } t_bus;

endpackage

@@ rtl/core/positional_list_engine.sv @@
// positional list engine: an ordered list of up to CAPACITY signed 32-bit
// words kept in a row of cells, one word per cell, plus an element count.
// a request carries get, locate, insert, delete or clear and yields exactly
// one response with status, data, match position, new length and an empty
// flag. insert and delete move every cell behind the position one step at
// once, each cell taking its neighbor's word. get, delete and locate
// read through a result bus that runs down the row one cell per cycle, so a
// request that reads the list (get or delete with a good position, and any
// locate) runs a sweep over the whole row before its response is formed;
// insert, clear, unused op codes and out-of-range requests skip the sweep.
// one request is in flight at a time; the next one is taken as soon as the
// response is loaded into the output register, even while that response
// still waits to be taken. no clearing pass is needed after reset: words at
// or beyond the count are never read.
module positional_list_engine #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  plist_pkg::t_req i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output plist_pkg::t_rsp o_rsp
);
    import plist_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > POSW) ? CW : POSW) + 1;
    localparam logic [CW-1:0]   CAP_CNT    = CW'(CAPACITY);
    localparam logic [SW-1:0]   SWEEP_LAST = SW'(CAPACITY - 1);
    localparam logic [CMPW-1:0] ONE        = CMPW'(1);

    // sequencer state
    t_state         r_state;
    t_state         n_state;
    logic [SW-1:0]  r_sweep;
    logic [SW-1:0]  n_sweep;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    t_req           r_req;
    t_rsp           r_rsp;
    t_rsp           n_rsp;
    logic           r_rsp_valid;
    logic           n_rsp_valid;

    logic           w_accept;
    logic           w_apply;
    logic           w_need_sweep;
    logic           w_in_ok;
    logic           w_get_ok;
    logic           w_ins_ok;
    logic           w_full;
    t_cell_ctl      w_ctl;

    logic signed [WORDW-1:0] w_word  [CAPACITY];
    logic signed [WORDW-1:0] w_left  [CAPACITY];
    logic signed [WORDW-1:0] w_right [CAPACITY];
    t_bus                    w_bus   [CAPACITY];
    t_bus                    w_bus_in[CAPACITY];

    assign w_accept = i_req_valid && o_req_ready;

    // range check of the incoming request, picks whether the bus sweep runs
    always_comb begin
        w_in_ok = (CMPW'(i_req.position) >= ONE) &&
                  (CMPW'(i_req.position) <= CMPW'(r_count));
        case (i_req.op)
            OP_GET, OP_DELETE: w_need_sweep = w_in_ok;
            OP_LOCATE:         w_need_sweep = 1'b1;
            default:           w_need_sweep = 1'b0;
        endcase
    end

    // range checks of the held request, count is unchanged since acceptance
    always_comb begin
        w_get_ok = (CMPW'(r_req.position) >= ONE) &&
                   (CMPW'(r_req.position) <= CMPW'(r_count));
        w_ins_ok = (CMPW'(r_req.position) >= ONE) &&
                   (CMPW'(r_req.position) <= (CMPW'(r_count) + ONE));
        w_full   = r_count == CAP_CNT;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_need_sweep ? S_SWEEP : S_FIN;
                end
            end
            S_SWEEP: begin
                if (r_sweep == SWEEP_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_apply) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_req_ready = r_state == S_IDLE;
        w_apply     = (r_state == S_FIN) && (!r_rsp_valid || i_rsp_ready);
        n_sweep     = (r_state == S_SWEEP) ? r_sweep + SW'(1) : '0;

        w_ctl.locate = r_req.op == OP_LOCATE;
        w_ctl.ins    = w_apply && (r_req.op == OP_INSERT) && w_ins_ok && !w_full;
        w_ctl.del    = w_apply && (r_req.op == OP_DELETE) && w_get_ok;
        w_ctl.pos    = r_req.position;
        w_ctl.value  = r_req.value;
    end

    // response and new count, formed from the bus head at the end of the sweep
    always_comb begin
        n_rsp.status   = ST_OK;
        n_rsp.data_out = '0;
        n_rsp.found_at = '0;
        n_count        = r_count;
        case (r_req.op)
            OP_GET: begin
                if (w_get_ok) begin
                    n_rsp.data_out = w_bus[0].word;
                end else begin
                    n_rsp.status   = ST_RANGE;
                    n_rsp.data_out = ERR_DATA;
                end
            end
            OP_LOCATE: begin
                n_rsp.found_at = w_bus[0].hit ? w_bus[0].place : '0;
            end
            OP_INSERT: begin
                if (!w_ins_ok) begin
                    n_rsp.status   = ST_RANGE;
                    n_rsp.data_out = ERR_DATA;
                end else if (w_full) begin
                    n_rsp.status   = ST_FULL;
                    n_rsp.data_out = ERR_DATA;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_DELETE: begin
                if (w_get_ok) begin
                    n_rsp.data_out = w_bus[0].word;
                    n_count        = r_count - CW'(1);
                end else begin
                    n_rsp.status   = ST_RANGE;
                    n_rsp.data_out = ERR_DATA;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.count_after = POSW'(n_count);
        n_rsp.is_empty    = n_count == '0;
        n_rsp_valid       = w_apply || (r_rsp_valid && !i_rsp_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sweep     <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_rsp_valid <= n_rsp_valid;
            if (w_apply) begin
                r_count <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (w_apply) begin
            r_rsp <= n_rsp;
        end
    end

    // row of cells; ends of the row see their own word, the tail an empty bus
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign w_left[gi] = w_word[gi];
        end else begin : g_mid_l
            assign w_left[gi] = w_word[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right[gi]  = w_word[gi];
            assign w_bus_in[gi] = '0;
        end else begin : g_mid_r
            assign w_right[gi]  = w_word[gi+1];
            assign w_bus_in[gi] = w_bus[gi+1];
        end

        plist_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_left_word  (w_left[gi]),
            .i_right_word (w_right[gi]),
            .i_bus        (w_bus_in[gi]),
            .o_word       (w_word[gi]),
            .o_bus        (w_bus[gi])
        );
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ rtl/core/plist_cell.sv @@
module plist_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                              i_clk,
    input  plist_pkg::t_cell_ctl              i_ctl,
    input  logic [CW-1:0]                     i_count,
    input  logic signed [plist_pkg::WORDW-1:0] i_left_word,
    input  logic signed [plist_pkg::WORDW-1:0] i_right_word,
    input  plist_pkg::t_bus                   i_bus,
    output logic signed [plist_pkg::WORDW-1:0] o_word,
    output plist_pkg::t_bus                   o_bus
);
    import plist_pkg::*;

    localparam int CMPW = ((CW > POSW) ? CW : POSW) + 1;
    localparam logic [CMPW-1:0] MY_IDX   = CMPW'(IDX);
    localparam logic [CMPW-1:0] MY_PLACE = CMPW'(IDX + 1);

    logic signed [WORDW-1:0] r_word;
    logic signed [WORDW-1:0] n_word;
    t_bus                    r_bus;
    t_bus                    n_bus;
    logic                    w_hit;
    logic                    w_live;
    logic                    w_at;
    logic                    w_above;

    always_comb begin
        w_live  = CMPW'(i_count) > MY_IDX;
        w_at    = MY_PLACE == CMPW'(i_ctl.pos);
        w_above = MY_PLACE > CMPW'(i_ctl.pos);
        w_hit   = i_ctl.locate ? (w_live && (r_word == i_ctl.value)) : w_at;
    end

    always_comb begin
        if (w_hit) begin
            n_bus.hit   = 1'b1;
            n_bus.word  = r_word;
            n_bus.place = POSW'(IDX + 1);
        end else begin
            n_bus = i_bus;
        end
    end

    always_comb begin
        n_word = r_word;
        if (i_ctl.ins) begin
            if (w_above) begin
                n_word = i_left_word;
            end else if (w_at) begin
                n_word = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (w_above || w_at) begin
                n_word = i_right_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_bus  <= n_bus;
    end

    assign o_word = r_word;
    assign o_bus  = r_bus;

endmodule

@@ rtl/core/plist_checker.sv @@
module plist_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            o_req_ready,
    input plist_pkg::t_req i_req,
    input logic            o_rsp_valid,
    input logic            i_rsp_ready,
    input plist_pkg::t_rsp o_rsp
);
    import plist_pkg::*;

    // reset empties the response register
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // empty flag agrees with the reported length
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.is_empty == (o_rsp.count_after == '0)))
        else $error("empty flag disagrees with length");

    // any error status returns all ones and no match
    a_err_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != ST_OK) |->
            (o_rsp.data_out == ERR_DATA) && (o_rsp.found_at == '0))
        else $error("error response carries data");

    // a new response only follows an accepted request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp_valid ##1 o_rsp_valid |-> $past(!o_req_ready, 1))
        else $error("response without request");

endmodule

bind positional_list_engine plist_checker u_plist_checker (.*);

@@ bench/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps

module tb_positional_list_engine;
    import plist_pkg::*;

    localparam int LIST_CAP       = CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int MAX_GAP        = 19;
    // receiver goes quiet once, after this many responses, for this long
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 500;
    // reads sweep the whole row of cells, so allow a full sweep plus slack
    localparam int DRAIN_CYCLES   = LIST_CAP + 8;
    localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + LIST_CAP + 2 + 2 * MAX_GAP);

    // codes the block ignores
    localparam t_op OP_UNUSED_5 = t_op'(3'd5);
    localparam t_op OP_UNUSED_7 = t_op'(3'd7);

    // flavor of a random episode
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BLEND,
        MIX_NOISE
    } t_mix;

    // one line of the directed table: the request and, where typed in, its answer
    typedef struct packed {
        t_req  req;
        logic  typed;
        t_rsp  want;
    } t_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req       = '0;
    logic i_rsp_ready = 1'b0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // shadow copy of the list, updated at each accepted request
    logic signed [WORDW-1:0] list_words [0:LIST_CAP-1];
    int                      list_len = 0;

    t_row row_tags[$];      // table tag per request, in send order
    t_rsp awaited_rsp[$];   // answers still owed by the block

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int directed_sent = 0;
    int random_sent   = 0;
    int checked       = 0;
    int full_rsp      = 0;
    int range_rsp     = 0;
    int located       = 0;

    positional_list_engine #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial forever #5 i_clk = ~i_clk;

    // reset held at start, released on a falling edge, never again
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // list behavior: applies one request to the shadow list, returns its answer
    function automatic t_rsp apply_request(t_req r);
        t_rsp rsp;
        int   p;
        int   k;
        rsp        = '0;
        rsp.status = ST_OK;
        p          = int'(r.position);
        case (r.op)
            OP_GET: begin
                if (p >= 1 && p <= list_len) begin
                    rsp.data_out = list_words[p-1];
                end else begin
                    rsp.status   = ST_RANGE;
                    rsp.data_out = ERR_DATA;
                end
            end
            OP_LOCATE: begin
                // first match wins
                for (k = 0; k < list_len; k++) begin
                    if (rsp.found_at == 0 && list_words[k] == r.value) begin
                        rsp.found_at = POSW'(k + 1);
                    end
                end
            end
            OP_INSERT: begin
                // position is checked before fullness
                if (p < 1 || p > list_len + 1) begin
                    rsp.status   = ST_RANGE;
                    rsp.data_out = ERR_DATA;
                end else if (list_len >= LIST_CAP) begin
                    rsp.status   = ST_FULL;
                    rsp.data_out = ERR_DATA;
                end else begin
                    for (k = list_len; k > p - 1; k--) begin
                        list_words[k] = list_words[k-1];
                    end
                    list_words[p-1] = r.value;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (p >= 1 && p <= list_len) begin
                    rsp.data_out = list_words[p-1];
                    for (k = p - 1; k + 1 < list_len; k++) begin
                        list_words[k] = list_words[k+1];
                    end
                    list_len--;
                end else begin
                    rsp.status   = ST_RANGE;
                    rsp.data_out = ERR_DATA;
                end
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
                // unused codes leave the list alone
            end
        endcase
        rsp.count_after = POSW'(list_len);
        rsp.is_empty    = (list_len == 0);
        return rsp;
    endfunction

    // table line checked against the shadow list
    function automatic t_row plain_row(t_op op, int pos, logic [WORDW-1:0] val);
        t_row r;
        r              = '0;
        r.req.op       = op;
        r.req.position = POSW'(pos);
        r.req.value    = val;
        return r;
    endfunction

    // table line with its answer written out
    function automatic t_row typed_row(t_op op, int pos, logic [WORDW-1:0] val,
                                       t_status st, logic [WORDW-1:0] data,
                                       int found, int cnt, int empty);
        t_row r;
        r                  = plain_row(op, pos, val);
        r.typed            = 1'b1;
        r.want.status      = st;
        r.want.data_out    = data;
        r.want.found_at    = POSW'(found);
        r.want.count_after = POSW'(cnt);
        r.want.is_empty    = 1'(empty);
        return r;
    endfunction

    // random request shaped by the episode flavor and the current length
    function automatic t_req random_request(t_mix mix);
        t_req r;
        int   roll;
        int   hi;
        r    = '0;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   r.op = t_op'(roll < 80 ? OP_INSERT : roll < 88 ? OP_GET :
                                     roll < 96 ? OP_LOCATE : OP_DELETE);
            MIX_SHRINK: r.op = t_op'(roll < 60 ? OP_DELETE : roll < 75 ? OP_GET :
                                     roll < 90 ? OP_LOCATE : OP_INSERT);
            MIX_BLEND:  r.op = t_op'(roll < 30 ? OP_INSERT : roll < 50 ? OP_DELETE :
                                     roll < 72 ? OP_GET : roll < 97 ? OP_LOCATE :
                                     OP_CLEAR);
            default:    r.op = t_op'($urandom_range(0, 7));
        endcase

        // mostly legal positions with the ends favored, some anywhere in 0..127
        hi = (r.op == OP_INSERT) ? list_len + 1 : list_len;
        if (mix == MIX_NOISE || hi == 0 || $urandom_range(0, 99) < 12) begin
            r.position = POSW'($urandom_range(0, 127));
        end else begin
            roll = $urandom_range(0, 9);
            r.position = POSW'(roll == 0 ? 1 : roll == 1 ? hi : $urandom_range(1, hi));
        end

        // values already in the list make locate hit and create duplicates
        roll = $urandom_range(0, 9);
        if (roll < 4 && list_len > 0) begin
            r.value = list_words[$urandom_range(0, list_len - 1)];
        end else if (roll < 6) begin
            case ($urandom_range(0, 4))
                0:       r.value = 32'h8000_0000;
                1:       r.value = 32'h7FFF_FFFF;
                2:       r.value = 32'hFFFF_FFFF;
                3:       r.value = 32'h0000_0000;
                default: r.value = 32'h0000_0001;
            endcase
        end else begin
            r.value = $urandom;
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] expv, logic [63:0] actv);
        if (actv !== expv) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
            mismatches++;
        end
    endtask

    // offers one request after a random gap and holds it until taken
    task automatic send_request(t_row row, bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_tags.push_back(row);
        i_req       <= row.req;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        @(negedge i_clk);
    endtask

    // request and response monitor: predicts on acceptance, checks in order
    always @(posedge i_clk) begin
        t_row tag;
        t_rsp exp_rsp;
        if (i_rst_n) begin
            if (i_req_valid && o_req_ready) begin
                tag     = row_tags.pop_front();
                exp_rsp = apply_request(i_req);
                if (tag.typed) begin
                    exp_rsp = tag.want;
                end
                awaited_rsp.push_back(exp_rsp);
            end
            if (o_rsp_valid && i_rsp_ready) begin
                if (awaited_rsp.size() == 0) begin
                    $error("response with no request outstanding: 0x%0h", o_rsp);
                    mismatches++;
                end else begin
                    exp_rsp = awaited_rsp.pop_front();
                    compare_field("status",      64'(exp_rsp.status),
                                  64'(o_rsp.status));
                    compare_field("data_out",    64'(exp_rsp.data_out),
                                  64'(o_rsp.data_out));
                    compare_field("found_at",    64'(exp_rsp.found_at),
                                  64'(o_rsp.found_at));
                    compare_field("count_after", 64'(exp_rsp.count_after),
                                  64'(o_rsp.count_after));
                    compare_field("is_empty",    64'(exp_rsp.is_empty),
                                  64'(o_rsp.is_empty));
                    checked++;
                    if (exp_rsp.status == ST_FULL) full_rsp++;
                    if (exp_rsp.status == ST_RANGE) range_rsp++;
                    if (exp_rsp.found_at != 0) located++;
                end
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL positional_list_engine");
                $finish;
            end
        end
    end

    // response side: random stalls, calm stretches, one long hold-off
    initial begin
        int hold;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            // long hold-off so the block fills up and stalls its input
            if (taken == HOLD_AT) hold = HOLD_CYCLES;
            if (hold > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (!o_rsp_valid);
            taken++;
            @(negedge i_clk);
        end
    end

    // request side: directed table, then random episodes, then drain
    initial begin
        t_row table_rows[$];
        t_row row;
        t_mix mix;
        int   episode_len;
        int   roll;
        int   n;
        bit   calm;

        // empty list: every read is out of range, locate finds nothing
        table_rows.push_back(typed_row(OP_GET,    1, 0, ST_RANGE, ERR_DATA, 0, 0, 1));
        table_rows.push_back(typed_row(OP_LOCATE, 0, 0, ST_OK,    0,        0, 0, 1));
        table_rows.push_back(typed_row(OP_DELETE, 1, 0, ST_RANGE, ERR_DATA, 0, 0, 1));
        // insert at position zero and beyond count+1
        table_rows.push_back(typed_row(OP_INSERT, 0, 5, ST_RANGE, ERR_DATA, 0, 0, 1));
        table_rows.push_back(typed_row(OP_INSERT, 2, 5, ST_RANGE, ERR_DATA, 0, 0, 1));
        // build max, min, -1 using front and back inserts
        table_rows.push_back(typed_row(OP_INSERT, 1, 32'h7FFF_FFFF, ST_OK, 0, 0, 1, 0));
        table_rows.push_back(typed_row(OP_INSERT, 1, 32'h8000_0000, ST_OK, 0, 0, 2, 0));
        table_rows.push_back(typed_row(OP_INSERT, 3, 32'hFFFF_FFFF, ST_OK, 0, 0, 3, 0));
        table_rows.push_back(typed_row(OP_GET, 1, 0, ST_OK, 32'h8000_0000, 0, 3, 0));
        table_rows.push_back(typed_row(OP_GET, 3, 0, ST_OK, 32'hFFFF_FFFF, 0, 3, 0));
        table_rows.push_back(typed_row(OP_GET, 127, 0, ST_RANGE, ERR_DATA, 0, 3, 0));
        table_rows.push_back(typed_row(OP_LOCATE, 0, 32'h7FFF_FFFF, ST_OK, 0, 2, 3, 0));
        table_rows.push_back(plain_row(OP_LOCATE, 0, 5));
        // duplicate value: locate must report the first copy
        table_rows.push_back(plain_row(OP_INSERT, 2, 32'h7FFF_FFFF));
        table_rows.push_back(plain_row(OP_LOCATE, 127, 32'h7FFF_FFFF));
        // unused codes change nothing
        table_rows.push_back(typed_row(OP_UNUSED_5, 1, 5, ST_OK, 0, 0, 4, 0));
        table_rows.push_back(typed_row(OP_UNUSED_7, 127, 32'hFFFF_FFFF, ST_OK, 0, 0, 4, 0));
        table_rows.push_back(plain_row(OP_DELETE, 2, 0));
        table_rows.push_back(typed_row(OP_DELETE, 4, 0, ST_RANGE, ERR_DATA, 0, 3, 0));
        // append at count+1, then one further is out of range
        table_rows.push_back(plain_row(OP_INSERT, 4, 32'h1234_5678));
        table_rows.push_back(typed_row(OP_INSERT, 6, 0, ST_RANGE, ERR_DATA, 0, 4, 0));
        // delete last and first
        table_rows.push_back(plain_row(OP_DELETE, 4, 0));
        table_rows.push_back(plain_row(OP_DELETE, 1, 0));
        // clear, then stale words must not be found
        table_rows.push_back(typed_row(OP_CLEAR, 0, 0, ST_OK, 0, 0, 0, 1));
        table_rows.push_back(typed_row(OP_LOCATE, 0, 32'h7FFF_FFFF, ST_OK, 0, 0, 0, 1));

        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        foreach (table_rows[i]) begin
            send_request(table_rows[i], 1'b0);
            directed_sent++;
        end

        // random episodes: grow runs reach a full list, shrink runs empty it
        while (random_sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            mix  = roll < 4 ? MIX_GROW : roll < 6 ? MIX_SHRINK :
                   roll < 9 ? MIX_BLEND : MIX_NOISE;
            episode_len = (mix == MIX_GROW) ? $urandom_range(90, 160) :
                          $urandom_range(20, 100);
            calm = ($urandom_range(0, 4) == 0);
            for (n = 0; n < episode_len && random_sent < RANDOM_ITEMS; n++) begin
                row     = '0;
                row.req = random_request(mix);
                send_request(row, calm);
                // ignored codes do not count toward the random total
                if (row.req.op <= OP_CLEAR) random_sent++;
            end
        end
        i_req_valid <= 1'b0;

        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_rsp.size() != 0) begin
            $error("%0d responses never arrived", awaited_rsp.size());
            mismatches++;
        end

        $display("covered %0d table and %0d random requests, %0d responses checked",
                 directed_sent, random_sent, checked);
        $display("full-list answers %0d, out-of-range answers %0d, locate hits %0d",
                 full_rsp, range_rsp, located);
        if (mismatches == 0) begin
            $display("PASS positional_list_engine");
        end else begin
            $display("FAIL positional_list_engine");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/plist_pkg.sv
rtl/core/plist_cell.sv
rtl/core/positional_list_engine.sv
rtl/core/plist_checker.sv
bench/tb_positional_list_engine.sv
